>>> rtl/bcpf_pkg.sv
// Shared constants, types and helpers for the binary command packetizer.
`default_nettype none

package bcpf_pkg;

    localparam int MAX_TEXT    = 64;
    localparam int FIELD_COUNT = 14;
    localparam int V1_TEXT     = 16;

    localparam int TEXT_W = $clog2(MAX_TEXT + 1);
    localparam int CUR_W  = $clog2(FIELD_COUNT + 1);
    // longest burst of one item: version-1 padding plus two checksum bytes
    localparam int BCNT_W = $clog2(V1_TEXT + 3);

    // primary mask bits with a meaning of their own
    localparam int MB_V2   = 12;
    localparam int MB_TEXT = 15;

    typedef enum logic [1:0] {
        OP_HEADER = 2'd0,
        OP_VALUE  = 2'd1,
        OP_TEXT   = 2'd2,
        OP_FINISH = 2'd3
    } opcode_t;

    typedef struct packed {
        logic latch;
        logic decode;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic final_byte;
    } dp_stat_t;

    function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 9'd255)
        begin
            s = s - 9'd255;
        end
        return s[7:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/bcpf_in_if.sv
// Command item channel: valid/ready handshake with the item fields.
`default_nettype none

interface bcpf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] value;
    logic [2:0]  extra_mask;
    logic [6:0]  text_length;

    modport source (output valid, output opcode, output value, output extra_mask,
                    output text_length, input ready);
    modport sink   (input valid, input opcode, input value, input extra_mask,
                    input text_length, output ready);
endinterface

`default_nettype wire

>>> rtl/bcpf_out_if.sv
// Packet byte channel: valid/ready handshake with one packet byte per transfer.
`default_nettype none

interface bcpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;
    logic       malformed;

    modport source (output valid, output packet_byte, output last_byte,
                    output malformed, input ready);
    modport sink   (input valid, input packet_byte, input last_byte,
                    input malformed, output ready);
endinterface

`default_nettype wire

>>> rtl/bcpf_dp.sv
// Datapath: packet state, field cursor, byte selection and Fletcher sums.
`default_nettype none

module bcpf_dp
    import bcpf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    output dp_stat_t         stat,
    input  wire logic [1:0]  in_opcode,
    input  wire logic [31:0] in_value,
    input  wire logic [2:0]  in_extra_mask,
    input  wire logic [6:0]  in_text_length,
    output logic [7:0]       packet_byte,
    output logic             last_byte,
    output logic             malformed
);

    // latched item
    opcode_t     op_reg;
    logic [31:0] val_reg;
    logic [2:0]  xm_reg;
    logic [6:0]  tl_reg;

    // packet state
    logic [15:0]       pmask_reg;
    logic [2:0]        smask_reg;
    logic [CUR_W-1:0]  cursor_reg;
    logic [TEXT_W-1:0] tcount_reg;
    logic [TEXT_W-1:0] ttotal_reg;
    logic [7:0]        sum1_reg;
    logic [7:0]        sum2_reg;
    logic              err_reg;
    logic              open_reg;

    // burst sequencing
    logic [BCNT_W-1:0] total_reg;
    logic [BCNT_W-1:0] k_reg;
    logic [BCNT_W-1:0] pad_reg;

    // output register
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       mal_reg;

    logic                    v2;
    logic                    txt;
    logic [FIELD_COUNT-1:0]  pres;
    logic [FIELD_COUNT-1:0]  cand;
    logic [CUR_W-1:0]        idx;
    logic                    idx_found;
    logic [2:0]              fbytes;
    logic                    tl_over;
    logic [TEXT_W-1:0]       tl_sat;
    logic                    text_ok;
    logic                    text_out;
    logic [BCNT_W-1:0]       sent;
    logic [BCNT_W-1:0]       pad;
    logic [BCNT_W-1:0]       nbytes;
    logic [7:0]              emit_byte;
    logic                    emit_sum;
    logic                    emit_last;
    logic [7:0]              sum1_new;
    logic [7:0]              sum2_new;

    assign v2  = pmask_reg[MB_V2];
    assign txt = pmask_reg[MB_TEXT];

    // presence in field order: N M G X Y Z E | F T S P | I J R
    assign pres = {smask_reg & {3{v2}}, pmask_reg[11:8], pmask_reg[6:0]};
    assign cand = pres & ~((FIELD_COUNT'(1) << cursor_reg) - FIELD_COUNT'(1));

    always_comb
    begin
        idx = CUR_W'(FIELD_COUNT);
        for (int i = FIELD_COUNT - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                idx = CUR_W'(i);
            end
        end
    end

    assign idx_found = (cand != '0);

    always_comb
    begin
        priority if (idx == CUR_W'(0))
        begin
            fbytes = 3'd2;
        end
        else if (idx == CUR_W'(1) || idx == CUR_W'(2))
        begin
            fbytes = v2 ? 3'd2 : 3'd1;
        end
        else if (idx == CUR_W'(8))
        begin
            fbytes = 3'd1;
        end
        else
        begin
            fbytes = 3'd4;
        end
    end

    assign tl_over  = (tl_reg > 7'(MAX_TEXT));
    assign tl_sat   = tl_over ? TEXT_W'(MAX_TEXT) : tl_reg[TEXT_W-1:0];
    assign text_ok  = txt && (tcount_reg < ttotal_reg);
    assign text_out = v2 || (tcount_reg < TEXT_W'(V1_TEXT));
    assign sent     = (tcount_reg < TEXT_W'(V1_TEXT)) ? BCNT_W'(tcount_reg)
                                                      : BCNT_W'(V1_TEXT);
    assign pad      = (txt && !v2) ? (BCNT_W'(V1_TEXT) - sent) : '0;

    always_comb
    begin
        unique case (op_reg)
            OP_HEADER:
            begin
                if (val_reg[MB_V2])
                begin
                    nbytes = val_reg[MB_TEXT] ? BCNT_W'(5) : BCNT_W'(4);
                end
                else
                begin
                    nbytes = BCNT_W'(2);
                end
            end
            OP_VALUE:  nbytes = (open_reg && idx_found) ? BCNT_W'(fbytes) : '0;
            OP_TEXT:   nbytes = (open_reg && text_ok && text_out) ? BCNT_W'(1) : '0;
            OP_FINISH: nbytes = open_reg ? (pad + BCNT_W'(2)) : '0;
            default:   nbytes = '0;
        endcase
    end

    // byte k of the current burst
    always_comb
    begin
        emit_byte = 8'd0;
        emit_sum  = 1'b1;
        emit_last = 1'b0;
        unique case (op_reg)
            OP_HEADER:
            begin
                unique case (k_reg)
                    BCNT_W'(0): emit_byte = pmask_reg[7:0];
                    BCNT_W'(1): emit_byte = pmask_reg[15:8];
                    BCNT_W'(2): emit_byte = {5'd0, smask_reg};
                    BCNT_W'(4): emit_byte = 8'(ttotal_reg);
                    default:    emit_byte = 8'd0;
                endcase
            end
            OP_VALUE:  emit_byte = val_reg[8*k_reg[1:0] +: 8];
            OP_TEXT:   emit_byte = val_reg[7:0];
            OP_FINISH:
            begin
                priority if (k_reg < pad_reg)
                begin
                    emit_byte = 8'd0;
                end
                else if (k_reg == pad_reg)
                begin
                    emit_byte = sum1_reg;
                    emit_sum  = 1'b0;
                end
                else
                begin
                    emit_byte = sum2_reg;
                    emit_sum  = 1'b0;
                    emit_last = 1'b1;
                end
            end
            default:   emit_byte = 8'd0;
        endcase
    end

    assign sum1_new = add_mod255(sum1_reg, emit_byte);
    assign sum2_new = add_mod255(sum2_reg, sum1_new);

    assign stat.empty      = (nbytes == '0);
    assign stat.final_byte = ((k_reg + BCNT_W'(1)) == total_reg);

    // item and output payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= opcode_t'(in_opcode);
            val_reg <= in_value;
            xm_reg  <= in_extra_mask;
            tl_reg  <= in_text_length;
        end
        if (cmd.emit)
        begin
            byte_reg <= emit_byte;
            last_reg <= emit_last;
            mal_reg  <= (op_reg == OP_FINISH) ? err_reg : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmask_reg  <= '0;
            smask_reg  <= '0;
            cursor_reg <= '0;
            tcount_reg <= '0;
            ttotal_reg <= '0;
            sum1_reg   <= '0;
            sum2_reg   <= '0;
            err_reg    <= 1'b0;
            open_reg   <= 1'b0;
            total_reg  <= '0;
            k_reg      <= '0;
            pad_reg    <= '0;
        end
        else if (cmd.decode)
        begin
            total_reg <= nbytes;
            k_reg     <= '0;
            pad_reg   <= pad;
            unique case (op_reg)
                OP_HEADER:
                begin
                    pmask_reg  <= val_reg[15:0];
                    smask_reg  <= xm_reg;
                    cursor_reg <= '0;
                    tcount_reg <= '0;
                    ttotal_reg <= val_reg[MB_TEXT] ? tl_sat : '0;
                    sum1_reg   <= '0;
                    sum2_reg   <= '0;
                    err_reg    <= val_reg[MB_TEXT] && tl_over;
                    open_reg   <= 1'b1;
                end
                OP_VALUE:
                begin
                    if (open_reg)
                    begin
                        if (idx_found)
                        begin
                            cursor_reg <= idx + CUR_W'(1);
                        end
                        else
                        begin
                            err_reg    <= 1'b1;
                            cursor_reg <= CUR_W'(FIELD_COUNT);
                        end
                    end
                end
                OP_TEXT:
                begin
                    if (open_reg)
                    begin
                        if (!text_ok)
                        begin
                            err_reg <= 1'b1;
                        end
                        else
                        begin
                            // skip unsent fields and flag an error if any remain
                            if (idx_found)
                            begin
                                err_reg <= 1'b1;
                            end
                            cursor_reg <= CUR_W'(FIELD_COUNT);
                            tcount_reg <= tcount_reg + TEXT_W'(1);
                        end
                    end
                end
                OP_FINISH:
                begin
                    if (open_reg && (idx_found || text_ok))
                    begin
                        err_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.emit)
        begin
            k_reg <= k_reg + BCNT_W'(1);
            if (emit_sum)
            begin
                sum1_reg <= sum1_new;
                sum2_reg <= sum2_new;
            end
            // close the packet on its last checksum byte
            if (op_reg == OP_FINISH && stat.final_byte)
            begin
                pmask_reg  <= '0;
                smask_reg  <= '0;
                cursor_reg <= '0;
                tcount_reg <= '0;
                ttotal_reg <= '0;
                sum1_reg   <= '0;
                sum2_reg   <= '0;
                err_reg    <= 1'b0;
                open_reg   <= 1'b0;
            end
        end
    end

    assign packet_byte = byte_reg;
    assign last_byte   = last_reg;
    assign malformed   = mal_reg;

endmodule

`default_nettype wire

>>> rtl/bcpf_ctrl.sv
// Controller: item acceptance, decode step and byte burst sequencing.
`default_nettype none

module bcpf_ctrl
    import bcpf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.latch  = (state_reg == ST_IDLE) && in_valid;
        cmd.decode = (state_reg == ST_DECODE);
        cmd.emit   = (state_reg == ST_EMIT) && slot_free;

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = stat.empty ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free && stat.final_byte)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        priority if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> rtl/binary_command_packetizer_fletcher16.sv
// Top level: command item to binary packet framer with Fletcher-16 trailer.
//
//   channel | dir | payload                                   | handshake
//   --------+-----+-------------------------------------------+------------
//   cmd     | in  | opcode, value, extra_mask, text_length    | valid/ready
//   pkt     | out | packet_byte, last_byte, malformed         | valid/ready
//
// An item is accepted, decoded and then emits its bytes one at a time: header
// 2 to 5 bytes, value 1 to 4, text 1, finish 2 to 18, and none for an ignored
// item or a version-1 character past the sixteenth. A single byte-wide
// Fletcher adder pair keeps the running sums.
// A stalled pkt channel holds the byte in the output register and freezes the
// burst; a new item is taken while the final byte still waits to be taken.
// rst_n clears the controller and all packet state asynchronously.
`default_nettype none

module binary_command_packetizer_fletcher16
    import bcpf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    bcpf_in_if.sink     cmd,
    bcpf_out_if.source  pkt
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;
    logic     in_ready;
    logic     out_valid;

    // Sequence the item: accept, decode, then emit bytes as the output frees.
    bcpf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (pkt.ready),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

    // Hold the packet state, pick each byte and advance the running sums.
    bcpf_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (dp_cmd),
        .stat           (dp_stat),
        .in_opcode      (cmd.opcode),
        .in_value       (cmd.value),
        .in_extra_mask  (cmd.extra_mask),
        .in_text_length (cmd.text_length),
        .packet_byte    (pkt.packet_byte),
        .last_byte      (pkt.last_byte),
        .malformed      (pkt.malformed)
    );

    assign cmd.ready = in_ready;
    assign pkt.valid = out_valid;

`ifndef SYNTHESIS
    // one item in flight: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("item accepted while previous item in flight");

    // never overwrite a byte that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.emit |-> (!pkt.valid || pkt.ready))
        else $error("output register overwritten while stalled");

    // the last byte of a burst returns the block to accepting items
    assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.emit && dp_stat.final_byte) |=> cmd.ready)
        else $error("block not ready after final byte of item");
`endif

endmodule

`default_nettype wire
